>>> rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// expression must never be true outside reset
`define ASSERT_NEVER(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define ASSERT_ALWAYS(label, clk, rst, prop, msg)
`define ASSERT_NEVER(label, clk, rst, expr, msg)
`endif

`endif

>>> rtl/itrd_pkg.sv
// Shared constants, types and helper functions for the radix digit converter
`default_nettype none

package itrd_pkg;

  localparam int VALUE_W    = 63;
  localparam int BASE_W     = 5;
  localparam int DIGIT_W    = 4;
  localparam int CHAR_W     = 8;
  localparam int MAX_DIGITS = 10;

  localparam int CNT_W = $clog2(VALUE_W);
  localparam int SP_W  = $clog2(MAX_DIGITS + 1);
  localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

  localparam logic [BASE_W-1:0] BASE_RESET = BASE_W'(10);
  localparam logic [BASE_W-1:0] BASE_MIN   = BASE_W'(2);
  localparam logic [BASE_W-1:0] BASE_MAX   = BASE_W'(16);

  localparam logic [CHAR_W-1:0] ASCII_ZERO  = CHAR_W'(48);
  localparam logic [CHAR_W-1:0] ASCII_ALPHA = CHAR_W'(55);
  localparam logic [DIGIT_W-1:0] DEC_MAX    = DIGIT_W'(9);

  // digit stack control
  typedef struct packed {
    logic clear;
    logic push;
    logic pop;
  } stk_ctl_t;

  // clamp the radix register to 2..16
  function automatic logic [BASE_W-1:0] eff_base(input logic [BASE_W-1:0] b);
    logic [BASE_W-1:0] r;
    r = b;
    if (b < BASE_MIN) r = BASE_MIN;
    if (b > BASE_MAX) r = BASE_MAX;
    return r;
  endfunction

  // digit value to '0'-'9' / 'A'-'F'
  function automatic logic [CHAR_W-1:0] ascii_of(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d <= DEC_MAX) c = CHAR_W'(d) + ASCII_ZERO;
    else              c = CHAR_W'(d) + ASCII_ALPHA;
    return c;
  endfunction

endpackage

`default_nettype wire

>>> rtl/itrd_div.sv
// Bit-serial restoring divider: one quotient bit per cycle, narrow remainder
`default_nettype none

module itrd_div (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  input  wire logic [itrd_pkg::VALUE_W-1:0]      dividend,
  input  wire logic [itrd_pkg::BASE_W-1:0]       divisor,
  output logic                                   done,
  output logic [itrd_pkg::VALUE_W-1:0]           quot,
  output logic [itrd_pkg::DIGIT_W-1:0]           rem
);

  logic                             busy;
  logic [itrd_pkg::CNT_W-1:0]       cnt;
  logic [itrd_pkg::VALUE_W-1:0]     q;
  logic [itrd_pkg::DIGIT_W-1:0]     r;

  logic [itrd_pkg::DIGIT_W:0]       trial;
  logic [itrd_pkg::DIGIT_W:0]       diff;
  logic                             ge;

  // shift next dividend bit into the partial remainder, subtract if it fits
  assign trial = {r, q[itrd_pkg::VALUE_W-1]};
  assign ge    = (trial >= (itrd_pkg::DIGIT_W+1)'(divisor));
  assign diff  = trial - (itrd_pkg::DIGIT_W+1)'(divisor);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= itrd_pkg::CNT_W'(itrd_pkg::VALUE_W - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q <= dividend;
      r <= '0;
    end else if (busy) begin
      q <= {q[itrd_pkg::VALUE_W-2:0], ge};
      r <= ge ? diff[itrd_pkg::DIGIT_W-1:0] : trial[itrd_pkg::DIGIT_W-1:0];
    end
  end

  assign quot = q;
  assign rem  = r;

endmodule

`default_nettype wire

>>> rtl/itrd_dstk.sv
// Digit stack: remainders pushed LSB first, popped MSB first as ASCII
`default_nettype none

module itrd_dstk (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire itrd_pkg::stk_ctl_t                ctl,
  input  wire logic [itrd_pkg::DIGIT_W-1:0]      digit,
  output logic [itrd_pkg::SP_W-1:0]              count,
  output logic [itrd_pkg::CHAR_W-1:0]            top_char
);

  logic [itrd_pkg::DIGIT_W-1:0] mem [itrd_pkg::MAX_DIGITS];
  logic [itrd_pkg::SP_W-1:0]    sp;
  logic [itrd_pkg::IDX_W-1:0]   wr_idx;
  logic [itrd_pkg::IDX_W-1:0]   rd_idx;

  assign wr_idx = itrd_pkg::IDX_W'(sp);
  assign rd_idx = itrd_pkg::IDX_W'(sp - 1'b1);

  always_ff @(posedge clk) begin
    if (rst) begin
      sp <= '0;
    end else if (ctl.clear) begin
      sp <= '0;
    end else if (ctl.push) begin
      sp <= sp + 1'b1;
    end else if (ctl.pop) begin
      sp <= sp - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem[wr_idx] <= digit;
    end
  end

  assign count    = sp;
  assign top_char = itrd_pkg::ascii_of(mem[rd_idx]);

endmodule

`default_nettype wire

>>> rtl/integer_to_radix_digits_core.sv
// Top level: integer to ASCII digit string in a configurable radix
//
//  channel | signals                           | direction | notes
//  --------+-----------------------------------+-----------+---------------------------
//  cfg     | cfg_valid, cfg_ready, dest_base   | in        | radix, reset 10, clamp 2..16
//  in      | in_valid, in_ready, value         | in        | 63-bit unsigned item
//  out     | out_valid, out_ready, digit_char, | out       | one item per digit, MSB first
//          | last, too_large                   |           |
//
//  Each digit is one pass of the bit-serial divider, after which its remainder is
//  pushed onto the digit stack. An item has at most 10 digits, which are then
//  unloaded MSB first; the output can be stalled by out_ready.
//  Items go through the one divider in turn; a new item is taken only once the
//  previous one's final digit sits in the output register.
//  rst is synchronous, active high; radix returns to 10, output goes empty.
`default_nettype none
`include "assert_macros.svh"

module integer_to_radix_digits_core (
  input  wire logic                              clk,
  input  wire logic                              rst,

  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [itrd_pkg::BASE_W-1:0]       dest_base,

  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [itrd_pkg::VALUE_W-1:0]      value,

  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [itrd_pkg::CHAR_W-1:0]            digit_char,
  output logic                                   last,
  output logic                                   too_large
);

  localparam logic [1:0] ST_IDLE = 2'd0;  // waiting for an item
  localparam logic [1:0] ST_DIV  = 2'd1;  // dividing, one digit per pass
  localparam logic [1:0] ST_EMIT = 2'd2;  // unloading digits MSB first

  logic [1:0]                        state;
  logic                              ovf;     // too-large result pending
  logic [itrd_pkg::BASE_W-1:0]       radix;

  logic                              in_acc;
  logic                              div_start;
  logic                              div_done;
  logic [itrd_pkg::VALUE_W-1:0]      div_value;
  logic [itrd_pkg::VALUE_W-1:0]      div_quot;
  logic [itrd_pkg::DIGIT_W-1:0]      div_rem;

  itrd_pkg::stk_ctl_t                stk_ctl;
  logic [itrd_pkg::SP_W-1:0]         stk_count;
  logic [itrd_pkg::CHAR_W-1:0]       stk_char;

  logic                              step_done;
  logic                              quot_zero;
  logic                              stk_full_next;
  logic                              last_dig;
  logic                              emit_load;

  // Radix register: config writes must only arrive while idle; the block itself does not enforce this
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      radix <= itrd_pkg::BASE_RESET;
    end else if (cfg_valid) begin
      radix <= dest_base;
    end
  end

  assign in_ready = (state == ST_IDLE);
  assign in_acc   = in_valid & in_ready;

  // A digit pass ends; the quotient feeds the next pass unless it is zero or the stack is full.
  // Ten digits with a non-zero quotient left means value >= radix^10.
  assign step_done     = (state == ST_DIV) & div_done;
  assign quot_zero     = (div_quot == '0);
  assign stk_full_next = (stk_count == itrd_pkg::SP_W'(itrd_pkg::MAX_DIGITS - 1));

  assign div_start = in_acc | (step_done & ~quot_zero & ~stk_full_next);
  assign div_value = in_acc ? value : div_quot;

  itrd_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_value),
    .divisor  (itrd_pkg::eff_base(radix)),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  // While emitting, the output register loads whenever it is empty or being drained
  assign emit_load = (state == ST_EMIT) & (~out_valid | out_ready);
  assign last_dig  = (stk_count == itrd_pkg::SP_W'(1));

  assign stk_ctl.push  = step_done;
  assign stk_ctl.clear = step_done & ~quot_zero & stk_full_next;
  assign stk_ctl.pop   = emit_load & ~ovf;

  itrd_dstk u_dstk (
    .clk      (clk),
    .rst      (rst),
    .ctl      (stk_ctl),
    .digit    (div_rem),
    .count    (stk_count),
    .top_char (stk_char)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      ovf   <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_acc) state <= ST_DIV;
        end
        ST_DIV: begin
          if (step_done) begin
            if (quot_zero) begin
              state <= ST_EMIT;
            end else if (stk_full_next) begin
              ovf   <= 1'b1;
              state <= ST_EMIT;
            end
          end
        end
        ST_EMIT: begin
          if (emit_load) begin
            if (ovf) begin
              ovf   <= 1'b0;
              state <= ST_IDLE;
            end else if (last_dig) begin
              state <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
          ovf   <= 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Loads stack top, last on final digit; too-large item: zero byte, last and flag set
  always_ff @(posedge clk) begin
    if (emit_load) begin
      digit_char <= ovf ? '0 : stk_char;
      last       <= ovf | last_dig;
      too_large  <= ovf;
    end
  end

  // The stack drains completely before the next item is taken
  `ASSERT_ALWAYS(a_idle_stack_empty, clk, rst, (state == ST_IDLE) |-> (stk_count == '0), "stack not empty while idle")
  // Divider completions only arrive while dividing
  `ASSERT_ALWAYS(a_done_in_div, clk, rst, div_done |-> (state == ST_DIV), "divider done outside divide state")
  // Never more digits than the stack depth MAX_DIGITS allows
  `ASSERT_NEVER(a_stack_bound, clk, rst, stk_count > itrd_pkg::SP_W'(itrd_pkg::MAX_DIGITS), "digit stack overflow")

endmodule

`default_nettype wire
